[rtl/thm_pkg.sv]
// ----------------------------------------------------------------------------
// thm_pkg
// Shared constants, register indexes and product helpers for the thermistor
// linearisation pipeline.
// ----------------------------------------------------------------------------
package thm_pkg;

  localparam int ADC_BITS = 12;
  localparam int DW       = ADC_BITS + 3;
  localparam int LW       = 20;
  localparam int EW       = 5;
  localparam int LOGW     = EW + 32;
  localparam int CW       = 41;
  localparam int RW       = 49;
  localparam int QW       = 21;
  localparam int NSTAGE   = 66;
  localparam int ST_RECIP = 44;

  localparam logic [2:0] REG_COEF_A      = 3'd0;
  localparam logic [2:0] REG_COEF_B      = 3'd1;
  localparam logic [2:0] REG_COEF_C      = 3'd2;
  localparam logic [2:0] REG_SERIES_OHMS = 3'd3;
  localparam logic [2:0] REG_LOW_OFFSET  = 3'd4;
  localparam logic [2:0] REG_HIGH_OFFSET = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SHORTED = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;

  localparam logic [63:0]     LN2_Q63    = 64'h58B9_0BFB_E8E7_BCD6;
  localparam logic [QW-1:0]   KELVIN_OFS = QW'(27315);
  localparam logic [QW-1:0]   TEMP_MAX   = QW'(1000000);
  localparam logic [QW-1:0]   TK_MAX     = QW'(1027315);
  localparam logic [RW-1:0]   NUM_SCALE  = RW'(100) << 40;

  typedef struct packed {
    logic [63:0] p00;
    logic [63:0] p01;
    logic [63:0] p10;
    logic [63:0] p11;
  } pp_t;

  function automatic pp_t pp_mul(input logic [63:0] a, input logic [63:0] b);
    pp_t pp;
    pp.p00 = a[31:0]  * b[31:0];
    pp.p01 = a[31:0]  * b[63:32];
    pp.p10 = a[63:32] * b[31:0];
    pp.p11 = a[63:32] * b[63:32];
    return pp;
  endfunction

  function automatic logic [127:0] pp_sum(input pp_t pp);
    return {pp.p11, 64'd0} + {32'd0, pp.p01, 32'd0} + {32'd0, pp.p10, 32'd0}
           + {64'd0, pp.p00};
  endfunction

endpackage

[rtl/thermistor_adc_to_temperature.sv]
// ----------------------------------------------------------------------------
// thermistor_adc_to_temperature
// Converts a raw thermistor divider count to temperature in 0.01 degC using
// the Steinhart-Hart equation, fully pipelined.
//
// Usage:
//   in_*   : one beat per ADC sample, in_tdata[11:0] holds the raw count.
//   out_*  : one beat per sample, out_tdata[20:0] temperature (signed),
//            out_tuser[1:0] status: 0 valid, 1 divider shorted, 2 bad reading.
//   cfg_*  : write coefficients, series resistor and offsets while idle.
//   From input beat to output beat the registered stages are, in order: the
//   corrected counts, the three parallel logarithm units (normalise, then one
//   squaring per stage), the log sum, the chained products, the reciprocal
//   sum, the quotient bits and the output register.
//   Throughput is one beat per cycle while the output is not stalled.
//   Reset clears every stage valid and loads the register defaults
//   (coefficients zero, series resistor 4700 ohms, offsets zero).
//   When out_tready is low with a beat waiting the whole pipeline holds and
//   in_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module thermistor_adc_to_temperature (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [11:0] adc_reading
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] temperature_centi
  output logic [1:0]  out_tuser,  // [1:0] status
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [40:0] cfg_wdata
);
  import thm_pkg::*;

  logic signed [CW-1:0] coef_a_r, coef_b_r, coef_c_r;
  logic [LW-1:0]        series_r;
  logic signed [7:0]    low_r, high_r;

  logic                 en;
  logic                 vld_r  [1:NSTAGE];
  logic [1:0]           code_r [1:NSTAGE];

  logic signed [DW-1:0] adc_s, den2_c, num2_c;
  logic [1:0]           code1_c;
  logic [DW-1:0]        num2_r, den2_r;
  logic [LOGW-1:0]      lg_rs, lg_num, lg_den;

  logic signed [LOGW+1:0] lg_c;
  logic [LOGW:0]        lg_mag_r;
  logic                 lg_neg_r;
  pp_t                  pp1_r;
  logic                 neg36_r;
  logic [127:0]         s1, s2, s3, s4, s5;
  logic [39:0]          ln37_r, ln38_r, ln39_r;
  logic                 lnneg37_r, lnneg38_r, lnneg39_r, lnneg40_r;
  pp_t                  pp2_r, pp4_r, pp3_r, pp5_r;
  logic [CW-1:0]        b_mag, c_mag;
  logic [47:0]          ln2_r, ln3_r, cl_r;
  logic [47:0]          bl39_r, bl40_r, bl41_r, bl42_r, bl43_r;
  logic                 blneg39_r, blneg40_r, blneg41_r, blneg42_r, blneg43_r;
  logic                 ln3neg_r, clneg42_r, clneg43_r;

  logic signed [RW:0]   blv, clv, recip_c;
  logic                 recip_ok;
  logic [1:0]           recip_code;
  logic [RW-1:0]        num_c;

  logic [RW-1:0]        dv_rem_r [0:QW];
  logic [RW-1:0]        dv_d_r   [0:QW];
  logic [QW-1:0]        dv_q_r   [0:QW];
  logic                 dv_sat_r [0:QW];
  logic [RW+QW-1:0]     dv_sub   [1:QW];
  logic                 dv_ge    [1:QW];

  logic [QW-1:0]        temp_r;
  logic [1:0]           status_r;

  assign en        = !vld_r[NSTAGE] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a_r <= '0;
      coef_b_r <= '0;
      coef_c_r <= '0;
      series_r <= LW'(4700);
      low_r    <= '0;
      high_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_COEF_A:      coef_a_r <= cfg_wdata;
        REG_COEF_B:      coef_b_r <= cfg_wdata;
        REG_COEF_C:      coef_c_r <= cfg_wdata;
        REG_SERIES_OHMS: series_r <= cfg_wdata[LW-1:0];
        REG_LOW_OFFSET:  low_r    <= cfg_wdata[7:0];
        REG_HIGH_OFFSET: high_r   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= NSTAGE; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      vld_r[1] <= in_tvalid;
      for (int k = 2; k <= NSTAGE; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_comb begin
    adc_s  = DW'(signed'({1'b0, in_tdata[ADC_BITS-1:0]}));
    den2_c = DW'(((DW'(1 << ADC_BITS) + DW'(high_r) - adc_s) <<< 1) - DW'(1));
    num2_c = DW'(((adc_s - DW'(low_r)) <<< 1) + DW'(1));
    if (den2_c[DW-1] || den2_c == '0) begin
      code1_c = ST_SHORTED;
    end else if (num2_c[DW-1] || num2_c == '0 || series_r == '0) begin
      code1_c = ST_BAD;
    end else begin
      code1_c = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      code_r[1] <= code1_c;
      num2_r    <= num2_c;
      den2_r    <= den2_c;
      for (int k = 2; k <= NSTAGE; k++) begin
        if (k == ST_RECIP) begin
          code_r[k] <= recip_code;
        end else begin
          code_r[k] <= code_r[k-1];
        end
      end
    end
  end

  thm_log2 u_log_rs  (.clk(clk), .en(en), .x_i(series_r), .lg_o(lg_rs));
  thm_log2 u_log_num (.clk(clk), .en(en), .x_i(LW'(num2_r)), .lg_o(lg_num));
  thm_log2 u_log_den (.clk(clk), .en(en), .x_i(LW'(den2_r)), .lg_o(lg_den));

  assign lg_c = signed'({2'b00, lg_rs}) + signed'({2'b00, lg_num})
              - signed'({2'b00, lg_den});
  assign s1 = pp_sum(pp1_r);
  assign s2 = pp_sum(pp2_r);
  assign s3 = pp_sum(pp3_r);
  assign s4 = pp_sum(pp4_r);
  assign s5 = pp_sum(pp5_r);
  assign b_mag = coef_b_r[CW-1] ? CW'(-coef_b_r) : CW'(coef_b_r);
  assign c_mag = coef_c_r[CW-1] ? CW'(-coef_c_r) : CW'(coef_c_r);

  always_ff @(posedge clk) begin
    if (en) begin
      lg_neg_r  <= lg_c[LOGW+1];
      lg_mag_r  <= lg_c[LOGW+1] ? (LOGW+1)'(-lg_c) : lg_c[LOGW:0];
      pp1_r     <= pp_mul(64'(lg_mag_r), LN2_Q63);
      neg36_r   <= lg_neg_r;
      ln37_r    <= s1[63 +: 40];
      lnneg37_r <= neg36_r;
      pp2_r     <= pp_mul(64'(ln37_r), 64'(ln37_r));
      pp4_r     <= pp_mul(64'(b_mag), 64'(ln37_r));
      ln38_r    <= ln37_r;
      lnneg38_r <= lnneg37_r;
      ln2_r     <= s2[32 +: 48];
      bl39_r    <= s4[32 +: 48];
      blneg39_r <= coef_b_r[CW-1] ^ lnneg38_r;
      ln39_r    <= ln38_r;
      lnneg39_r <= lnneg38_r;
      pp3_r     <= pp_mul(64'(ln2_r), 64'(ln39_r));
      lnneg40_r <= lnneg39_r;
      bl40_r    <= bl39_r;
      blneg40_r <= blneg39_r;
      ln3_r     <= s3[32 +: 48];
      ln3neg_r  <= lnneg40_r;
      bl41_r    <= bl40_r;
      blneg41_r <= blneg40_r;
      pp5_r     <= pp_mul(64'(c_mag), 64'(ln3_r));
      clneg42_r <= coef_c_r[CW-1] ^ ln3neg_r;
      bl42_r    <= bl41_r;
      blneg42_r <= blneg41_r;
      cl_r      <= s5[48 +: 48];
      clneg43_r <= clneg42_r;
      bl43_r    <= bl42_r;
      blneg43_r <= blneg42_r;
    end
  end

  always_comb begin
    blv      = blneg43_r ? -(RW+1)'(bl43_r) : (RW+1)'(bl43_r);
    clv      = clneg43_r ? -(RW+1)'(cl_r) : (RW+1)'(cl_r);
    recip_c  = (RW+1)'(coef_a_r) + blv + clv;
    recip_ok = !recip_c[RW] && recip_c != '0;
    recip_code = (code_r[ST_RECIP-1] == ST_OK && !recip_ok) ? ST_BAD
               : code_r[ST_RECIP-1];
    num_c    = NUM_SCALE + {1'b0, recip_c[RW-1:1]};
  end

  always_comb begin
    for (int k = 1; k <= QW; k++) begin
      dv_sub[k] = {{QW{1'b0}}, dv_d_r[k-1]} << (QW - k);
      dv_ge[k]  = {{QW{1'b0}}, dv_rem_r[k-1]} >= dv_sub[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem_r[0] <= num_c;
      dv_d_r[0]   <= recip_c[RW-1:0];
      dv_q_r[0]   <= '0;
      dv_sat_r[0] <= {{QW{1'b0}}, num_c} >= {recip_c[RW-1:0], {QW{1'b0}}};
      for (int k = 1; k <= QW; k++) begin
        dv_rem_r[k] <= dv_ge[k] ? dv_rem_r[k-1] - dv_sub[k][RW-1:0] : dv_rem_r[k-1];
        dv_d_r[k]   <= dv_d_r[k-1];
        dv_q_r[k]   <= {dv_q_r[k-1][QW-2:0], dv_ge[k]};
        dv_sat_r[k] <= dv_sat_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      status_r <= code_r[NSTAGE-1];
      case (code_r[NSTAGE-1])
        ST_SHORTED: temp_r <= QW'(-KELVIN_OFS);
        ST_OK: begin
          if (dv_sat_r[QW] || dv_q_r[QW] > TK_MAX) begin
            temp_r <= TEMP_MAX;
          end else begin
            temp_r <= dv_q_r[QW] - KELVIN_OFS;
          end
        end
        default: temp_r <= '0;
      endcase
    end
  end

  assign out_tvalid = vld_r[NSTAGE];
  assign out_tdata  = {3'b000, temp_r};
  assign out_tuser  = status_r;

endmodule

[rtl/thm_log2.sv]
// ----------------------------------------------------------------------------
// thm_log2
// Pipelined base-2 logarithm in Q32: normalise, then one squaring per stage.
// ----------------------------------------------------------------------------
module thm_log2 (
  input  logic                     clk,
  input  logic                     en,
  input  logic [thm_pkg::LW-1:0]   x_i,
  output logic [thm_pkg::LOGW-1:0] lg_o
);
  import thm_pkg::*;

  logic [EW-1:0]  e_r [0:32];
  logic [31:0]    m_r [0:32];
  logic [31:0]    f_r [0:32];
  logic [EW-1:0]  e_nxt;
  logic [LW+31:0] sh_nxt;
  logic [63:0]    sq [1:32];
  logic [32:0]    q  [1:32];

  always_comb begin
    e_nxt = '0;
    for (int i = 1; i < LW; i++) begin
      if (x_i[i]) begin
        e_nxt = EW'(i);
      end
    end
    sh_nxt = {32'd0, x_i} << (5'd31 - e_nxt);
  end

  always_comb begin
    for (int k = 1; k <= 32; k++) begin
      sq[k] = m_r[k-1] * m_r[k-1];
      q[k]  = sq[k][63:31];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_r[0] <= e_nxt;
      m_r[0] <= sh_nxt[31:0];
      f_r[0] <= '0;
      for (int k = 1; k <= 32; k++) begin
        e_r[k] <= e_r[k-1];
        m_r[k] <= q[k][32] ? q[k][32:1] : q[k][31:0];
        f_r[k] <= {f_r[k-1][30:0], q[k][32]};
      end
    end
  end

  assign lg_o = {e_r[32], f_r[32]};

endmodule

[rtl/thm_chk.sv]
// ----------------------------------------------------------------------------
// thm_chk
// Port-level checks for the thermistor linearisation block.
// ----------------------------------------------------------------------------
module thm_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import thm_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output beat changed while stalled");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while output stalled");

  a_shorted: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_SHORTED |-> out_tdata[20:0] == QW'(-KELVIN_OFS))
    else $error("shorted divider without absolute zero");

  a_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_BAD |-> out_tdata[20:0] == 21'd0 && out_tdata[23:21] == 3'd0)
    else $error("bad reading with non-zero temperature");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind thermistor_adc_to_temperature thm_chk u_thm_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);
